### src/bayer_superpixel_debayer_macros.svh
// Assertion helpers for the RTL; bayer_superpixel_debayer.sv includes them.
// Each macro expects clk and rst_n in scope.
`ifndef BAYER_SUPERPIXEL_DEBAYER_MACROS_SVH
`define BAYER_SUPERPIXEL_DEBAYER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSD_ASSERT_IMP(lbl, ante, cons, msg)
`define BSD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### src/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

    localparam int PIX_W      = 16;   // raw_pixel, red and blue ports
    localparam int GSUM_W     = 17;   // green_sum port
    localparam int BLK_W      = 11;   // out_col and out_row ports
    localparam int CFG_DATA_W = 13;   // widest register
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_W      = 13;   // image_width / image_height
    localparam int ROW_W      = 12;   // row counter
    localparam int MAX_HEIGHT = 4096;
    localparam int CMP_W      = 15;   // wide enough for any written width and for MAX_WIDTH below 32768

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_BAYER_PATTERN = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PAT_RGGB = 2'd0,
        PAT_BGGR = 2'd1,
        PAT_GBRG = 2'd2,
        PAT_GRBG = 2'd3
    } bayer_pattern_t;

endpackage

### src/bsd_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle.
module bsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold the last read word until the next read
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/bayer_superpixel_debayer.sv
`timescale 1ns / 1ps
// Bayer super-pixel debayer: one RGB triple per 2x2 block of raw pixels.
// Input channel: in_valid / in_ready with raw_pixel, one sample per transfer, raster
// order. Output channel: out_valid / out_ready with red, green_sum (sum of the two
// greens), blue, the block coordinates out_col / out_row and frame_last.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 image_width,
// 1 image_height, 2 bayer_pattern) at the clock edge; write only while idle.
// Throughput: one raw pixel per cycle, sustained, as long as the receiver keeps up.
// Latency: the triple is presented the cycle after the transfer of the bottom-right
// pixel of its block; it is built from the line store read that was launched one
// pixel earlier, so one output register is the only stage.
// The line store is two RAMs (even and odd columns) of (MAX_WIDTH+1)/2 entries each;
// even raw rows are written there and read back on the following odd row.
// Stall: the output register holds its triple while out_ready is low; in_ready
// drops only while a triple waits and the receiver is not taking it.
// Reset: counters, held pixel and output valid clear; registers return to width
// 4096, height 4096, RGGB. The line store is not cleared and needs no pass.
// Trailing odd columns or rows are consumed without a result.
module bayer_superpixel_debayer #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data,
    // raw pixel input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bsd_pkg::PIX_W-1:0]      raw_pixel,
    // RGB output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bsd_pkg::PIX_W-1:0]      red,
    output logic [bsd_pkg::GSUM_W-1:0]     green_sum,
    output logic [bsd_pkg::PIX_W-1:0]      blue,
    output logic [bsd_pkg::BLK_W-1:0]      out_col,
    output logic [bsd_pkg::BLK_W-1:0]      out_row,
    output logic                           frame_last
);

    import bsd_pkg::*;

`include "bayer_superpixel_debayer_macros.svh"

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int HALF_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam logic [CMP_W-1:0] MAXW_C = CMP_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAXH_C = DIM_W'(MAX_HEIGHT);

    // configuration registers
    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;
    bayer_pattern_t    pattern_reg;

    // stream state
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PIXEL_BITS-1:0] held_left_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]      red_reg;
    logic [GSUM_W-1:0]     green_reg;
    logic [PIX_W-1:0]      blue_reg;
    logic [BLK_W-1:0]      out_col_reg;
    logic [BLK_W-1:0]      out_row_reg;
    logic                  frame_last_reg;

    // datapath
    logic                  accept;
    logic                  produce;
    logic [PIXEL_BITS-1:0] pix;
    logic [CMP_W-1:0]      iw_ext, ew, ew_last, col_ext, col_inc;
    logic [DIM_W-1:0]      eh, eh_last, row_ext, row_inc;
    logic [ADDR_W-1:0]     pair_addr;
    logic [PIXEL_BITS-1:0] tl, tr, bl, br;
    logic [PIXEL_BITS-1:0] r_sel, b_sel;
    logic [PIXEL_BITS:0]   g_sel;
    logic                  wr_even, wr_odd, rd_pair;

    // ---------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_W'(4096);
            image_height_reg <= DIM_W'(4096);
            pattern_reg      <= PAT_RGGB;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:  image_height_reg <= cfg_data;
                CFG_BAYER_PATTERN: pattern_reg      <= bayer_pattern_t'(cfg_data[1:0]);
                default:           ; // drop writes to unused indexes
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Effective frame size and counter advance
    // ---------------------------------------------------------------
    always_comb
    begin
        iw_ext = CMP_W'(image_width_reg);
        if (iw_ext < CMP_W'(2))
            ew = CMP_W'(2);
        else if (iw_ext > MAXW_C)
            ew = MAXW_C;
        else
            ew = iw_ext;

        if (image_height_reg < DIM_W'(2))
            eh = DIM_W'(2);
        else if (image_height_reg > MAXH_C)
            eh = MAXH_C;
        else
            eh = image_height_reg;

        // last block ends at the last even-aligned odd column / row
        ew_last = (ew & ~CMP_W'(1)) - CMP_W'(1);
        eh_last = (eh & ~DIM_W'(1)) - DIM_W'(1);

        col_ext = CMP_W'(col_reg);
        col_inc = col_ext + CMP_W'(1);
        row_ext = DIM_W'(row_reg);
        row_inc = row_ext + DIM_W'(1);

        // wrap each counter once it reaches its bound (also after a shrink)
        if (col_inc >= ew)
        begin
            col_next = '0;
            row_next = (row_inc >= eh) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = (row_ext >= eh) ? '0 : row_reg;
        end
    end

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign pix      = raw_pixel[PIXEL_BITS-1:0];
    assign produce  = accept && row_reg[0] && col_reg[0];

    // ---------------------------------------------------------------
    // Line store: even row pixels go in by column parity; the pair for a
    // block is read when the bottom-left pixel transfers, so its words sit
    // in the RAM output registers when the bottom-right pixel arrives.
    // ---------------------------------------------------------------
    assign pair_addr = col_ext[ADDR_W:1];
    assign wr_even   = accept && !row_reg[0] && !col_reg[0];
    assign wr_odd    = accept && !row_reg[0] &&  col_reg[0];
    assign rd_pair   = accept &&  row_reg[0] && !col_reg[0];

    bsd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (HALF_DEPTH)
    ) u_even_ram (
        .clk     (clk),
        .wr_en   (wr_even),
        .wr_addr (pair_addr),
        .wr_data (pix),
        .rd_en   (rd_pair),
        .rd_addr (pair_addr),
        .rd_data (tl)
    );

    bsd_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (HALF_DEPTH)
    ) u_odd_ram (
        .clk     (clk),
        .wr_en   (wr_odd),
        .wr_addr (pair_addr),
        .wr_data (pix),
        .rd_en   (rd_pair),
        .rd_addr (pair_addr),
        .rd_data (tr)
    );

    // ---------------------------------------------------------------
    // Colour selection, sampled with the pattern current at this transfer
    // ---------------------------------------------------------------
    assign bl = held_left_reg;
    assign br = pix;

    always_comb
    begin
        case (pattern_reg)
            PAT_RGGB:
            begin
                r_sel = tl;
                b_sel = br;
                g_sel = {1'b0, tr} + {1'b0, bl};
            end
            PAT_BGGR:
            begin
                r_sel = br;
                b_sel = tl;
                g_sel = {1'b0, tr} + {1'b0, bl};
            end
            PAT_GBRG:
            begin
                r_sel = bl;
                b_sel = tr;
                g_sel = {1'b0, tl} + {1'b0, br};
            end
            default:
            begin
                r_sel = tr;
                b_sel = bl;
                g_sel = {1'b0, tl} + {1'b0, br};
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Counters and held bottom-left pixel
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            held_left_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (row_reg[0] && !col_reg[0])
            begin
                held_left_reg <= pix;
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register: load on a finished block, clear once transferred
    // ---------------------------------------------------------------
    always_comb
    begin
        if (produce)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            red_reg        <= PIX_W'(r_sel);
            green_reg      <= GSUM_W'(g_sel);
            blue_reg       <= PIX_W'(b_sel);
            out_col_reg    <= col_ext[BLK_W:1];
            out_row_reg    <= row_reg[BLK_W:1];
            frame_last_reg <= (row_ext == eh_last) && (col_ext == ew_last);
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green_sum  = green_reg;
    assign blue       = blue_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign frame_last = frame_last_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `BSD_ASSERT_NEXT(a_result_loaded, produce, out_valid_reg, "finished block not presented")
    `BSD_ASSERT_NEXT(a_even_row_silent, accept && !row_reg[0] && !out_valid_reg, !out_valid_reg, "even row pixel produced a result")
    `BSD_ASSERT_NEXT(a_stall_holds, out_valid_reg && !out_ready, out_valid_reg && $stable(green_reg) && $stable(out_col_reg), "stalled result changed")
    `BSD_ASSERT_NEXT(a_pair_follows, rd_pair && (col_inc < ew) && (row_ext < eh), row_reg[0] && col_reg[0], "bottom-left pixel not followed by its partner")
    `BSD_ASSERT_NEXT(a_left_held, rd_pair, held_left_reg == $past(pix), "bottom-left pixel not captured")

endmodule

### sim/tb_bayer_superpixel_debayer.sv
`timescale 1ns / 1ps

module tb_bayer_superpixel_debayer;

    import bsd_pkg::*;

    localparam int          RAW_AREA     = 4096;        // clamp bound for width and height
    localparam int          RANDOM_ITEMS = 1030;
    localparam int          WIDE_RUN     = 64;          // pixels along the clamped wide row
    localparam int          TALL_RUN     = 128;         // pixels down the clamped tall frame
    localparam int          CYCLE_LIMIT  = 4_000_000;
    localparam int          SETTLE       = 4;           // covers the single output stage
    localparam logic [1:0]  CFG_SPARE    = 2'd3;        // index with no register behind it

    // One output transfer, field for field as on the ports.
    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [GSUM_W-1:0] green_sum;
        logic [PIX_W-1:0]  blue;
        logic [BLK_W-1:0]  out_col;
        logic [BLK_W-1:0]  out_row;
        logic              frame_last;
    } rgb_block_t;

    // Mirrors the mosaic walk of the block and holds the triples still owed.
    class superpixel_scoreboard;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        bayer_pattern_t   pattern;
        logic [PIX_W-1:0] even_line [0:RAW_AREA-1];
        logic [PIX_W-1:0] held_left;
        int unsigned      col;
        int unsigned      row;
        rgb_block_t       pending_triples [$];
        int unsigned      triples_made;
        int unsigned      errors;

        function new();
            width_reg    = DIM_W'(RAW_AREA);
            height_reg   = DIM_W'(RAW_AREA);
            pattern      = PAT_RGGB;
            held_left    = '0;
            col          = 0;
            row          = 0;
            triples_made = 0;
            errors       = 0;
            foreach (even_line[i]) even_line[i] = '0;
        endfunction

        function int unsigned clamp_dim(logic [DIM_W-1:0] v);
            if (v < 2) return 2;
            if (v > RAW_AREA) return RAW_AREA;
            return v;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_IMAGE_WIDTH:   width_reg  = v;
                CFG_IMAGE_HEIGHT:  height_reg = v;
                CFG_BAYER_PATTERN: pattern    = bayer_pattern_t'(v[1:0]);
                default: ;
            endcase
        endfunction

        // Advance the walk by one accepted pixel; queue a triple on a
        // bottom-right site.
        function void note_pixel(logic [PIX_W-1:0] p);
            int unsigned      ew;
            int unsigned      eh;
            logic [PIX_W-1:0] tl;
            logic [PIX_W-1:0] tr;
            rgb_block_t       t;
            ew = clamp_dim(width_reg);
            eh = clamp_dim(height_reg);
            if (row[0] == 1'b0) begin
                even_line[col] = p;
            end
            else if (col[0] == 1'b0) begin
                held_left = p;
            end
            else begin
                tl = even_line[col - 1];
                tr = even_line[col];
                case (pattern)
                    PAT_RGGB: begin
                        t.red = tl; t.blue = p;  t.green_sum = GSUM_W'(tr) + GSUM_W'(held_left);
                    end
                    PAT_BGGR: begin
                        t.red = p;  t.blue = tl; t.green_sum = GSUM_W'(tr) + GSUM_W'(held_left);
                    end
                    PAT_GBRG: begin
                        t.red = held_left; t.blue = tr; t.green_sum = GSUM_W'(tl) + GSUM_W'(p);
                    end
                    default: begin
                        t.red = tr; t.blue = held_left; t.green_sum = GSUM_W'(tl) + GSUM_W'(p);
                    end
                endcase
                t.out_col    = BLK_W'(col >> 1);
                t.out_row    = BLK_W'(row >> 1);
                t.frame_last = (row == (eh / 2) * 2 - 1) && (col == (ew / 2) * 2 - 1);
                pending_triples.push_back(t);
                triples_made++;
            end
            col++;
            if (col >= ew) begin
                col = 0;
                row++;
                if (row >= eh) row = 0;
            end
            else if (row >= eh) begin
                row = 0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_triple(rgb_block_t got);
            rgb_block_t want;
            if (pending_triples.size() == 0) begin
                $display("%0t: triple with nothing owed, expected none actual %0h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_triples.pop_front();
            compare_field("red",        want.red,        got.red);
            compare_field("green_sum",  want.green_sum,  got.green_sum);
            compare_field("blue",       want.blue,       got.blue);
            compare_field("out_col",    want.out_col,    got.out_col);
            compare_field("out_row",    want.out_row,    got.out_row);
            compare_field("frame_last", want.frame_last, got.frame_last);
        endfunction

        function int unsigned owed();
            return pending_triples.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PIX_W-1:0]      raw_pixel;
    logic                  out_valid;
    logic                  out_ready;
    logic [PIX_W-1:0]      red;
    logic [GSUM_W-1:0]     green_sum;
    logic [PIX_W-1:0]      blue;
    logic [BLK_W-1:0]      out_col;
    logic [BLK_W-1:0]      out_row;
    logic                  frame_last;

    superpixel_scoreboard sb = new();
    int unsigned          cycle_count = 0;

    bayer_superpixel_debayer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_pixel  (raw_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green_sum  (green_sum),
        .blue       (blue),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_last (frame_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hang guard: the limit sits far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_bayer_superpixel_debayer: errors");
            $finish;
        end
    end

    // Check every output transfer; values read here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_triple(rgb_block_t'({red, green_sum, blue, out_col, out_row, frame_last}));
    end

    // Receiver: ready stretches of varied length broken by stalls, mostly short.
    initial
    begin
        int unsigned run;
        int unsigned hold;
        int unsigned pick;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            repeat (run) @(negedge clk) out_ready <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)      hold = $urandom_range(0, 2);
            else if (pick < 95) hold = $urandom_range(3, 8);
            else                hold = $urandom_range(20, 40);
            repeat (hold) @(negedge clk) out_ready <= 1'b0;
        end
    end

    // Sender gap between transfers: mostly none, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return PIX_W'($urandom);
    endfunction

    // Size register value: mostly small, some medium, rarely clamped or at the top.
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick == 0) return CFG_DATA_W'($urandom_range(0, 1));
        if (pick == 1) return CFG_DATA_W'($urandom_range(RAW_AREA, 8191));
        if (pick < 8)  return CFG_DATA_W'($urandom_range(13, 200));
        return CFG_DATA_W'($urandom_range(2, 12));
    endfunction

    task automatic hold_sender(int unsigned n);
        repeat (n) @(negedge clk) in_valid <= 1'b0;
    endtask

    // Present one pixel and hold it until the transfer; valid stays up afterwards
    // so that a following pixel goes out back to back.
    task automatic send_pixel(logic [PIX_W-1:0] p);
        @(negedge clk);
        in_valid  <= 1'b1;
        raw_pixel <= p;
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(p);
    endtask

    // Drop valid and wait until every owed triple has been transferred.
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (sb.owed() != 0) @(posedge clk);
    endtask

    // Registers change only once the block is idle; the trailing odd pixels of a
    // row leave no result, so let the output stage settle as well.
    task automatic settle();
        drain();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.note_config(idx, value);
    endtask

    task automatic end_writes();
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    // Rewrite a random subset of the registers. Called on an even raw row only:
    // the next odd row then reads line-store entries that have all been written.
    task automatic shuffle_config();
        logic [2:0] mask;
        mask = 3'($urandom_range(1, 7));
        if (mask[0]) write_reg(CFG_IMAGE_WIDTH, pick_dim());
        if (mask[1]) write_reg(CFG_IMAGE_HEIGHT, pick_dim());
        if (mask[2]) write_reg(CFG_BAYER_PATTERN, CFG_DATA_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        end_writes();
    endtask

    initial
    begin
        // Corner pixels (tl, tr, bl, br) of four 2x2 frames, one per pattern,
        // chosen to drive red, blue and the green sum to both ends.
        logic [PIX_W-1:0] corner_px [0:15] = '{
            16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
            16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
            16'hFFFF, 16'h1234, 16'hA5A5, 16'hFFFF,
            16'h0000, 16'h8000, 16'h7FFF, 16'h0001
        };
        int unsigned random_items;
        int unsigned burst;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        raw_pixel = '0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Smallest frame under each pattern: one block, which is also the last.
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(2));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        end_writes();
        for (int k = 0; k < 4; k++) begin
            settle();
            write_reg(CFG_BAYER_PATTERN, CFG_DATA_W'(bayer_pattern_t'(k)));
            end_writes();
            for (int i = 0; i < 4; i++) send_pixel(corner_px[4 * k + i]);
        end

        // Odd width and height: the trailing column and row give nothing.
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        write_reg(CFG_BAYER_PATTERN, CFG_DATA_W'(PAT_RGGB));
        end_writes();
        repeat (9) send_pixel(pick_pixel());

        // Width written above the limit so it clamps; a run along the first row
        // with no sender gaps.
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(8191));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        write_reg(CFG_BAYER_PATTERN, CFG_DATA_W'($urandom_range(0, 3)));
        end_writes();
        repeat (WIDE_RUN) send_pixel(pick_pixel());

        // Tall frame: width below the limit clamps to 2, height clamps to 4096;
        // walk down the first rows of it.
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(5000));
        end_writes();
        repeat (TALL_RUN) send_pixel(pick_pixel());

        // Random bursts. Registers change at frame starts and mid-frame alike, so
        // the counter wrap on a smaller bound gets exercised too.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (sb.row[0] == 1'b0 && $urandom_range(0, 2) == 0) begin
                settle();
                shuffle_config();
            end
            else if ($urandom_range(0, 5) == 0) begin
                // Pause the sender until the block has delivered everything owed.
                drain();
            end
            burst = $urandom_range(1, 48);
            repeat (burst) begin
                hold_sender(pick_gap());
                send_pixel(pick_pixel());
                random_items++;
            end
        end

        drain();
        repeat (4 * SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.owed() == 0)
            $display("tb_bayer_superpixel_debayer: clean");
        else
            $display("tb_bayer_superpixel_debayer: errors");
        $finish;
    end

endmodule
